// ===== src/gpt_pkg.sv =====
// Shared types, register indexes and constants for the general-purpose timer.
`timescale 1ns / 1ps

package gpt_pkg;

    // Default configuration of the timer core.
    localparam int COUNT_BITS_DEF = 16;
    localparam int CHANNELS_DEF   = 4;

    // Item kinds carried in the slave-side tuser.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    // Register word indexes.
    localparam logic [7:0] IDX_CONTROL_ONE    = 8'd0;
    localparam logic [7:0] IDX_CONTROL_TWO    = 8'd1;
    localparam logic [7:0] IDX_SLAVE_MODE     = 8'd2;
    localparam logic [7:0] IDX_IRQ_ENABLE     = 8'd3;
    localparam logic [7:0] IDX_STATUS         = 8'd4;
    localparam logic [7:0] IDX_EVENT_GEN      = 8'd5;
    localparam logic [7:0] IDX_MODE_0         = 8'd6;
    localparam logic [7:0] IDX_MODE_1         = 8'd7;
    localparam logic [7:0] IDX_CHANNEL_ENABLE = 8'd8;
    localparam logic [7:0] IDX_COUNT          = 8'd9;
    localparam logic [7:0] IDX_PRESCALE       = 8'd10;
    localparam logic [7:0] IDX_RELOAD         = 8'd11;
    localparam logic [7:0] IDX_REPEAT         = 8'd12;
    localparam logic [7:0] IDX_COMPARE_0      = 8'd13;
    localparam logic [7:0] IDX_COMPARE_1      = 8'd14;
    localparam logic [7:0] IDX_COMPARE_2      = 8'd15;
    localparam logic [7:0] IDX_COMPARE_3      = 8'd16;
    localparam logic [7:0] IDX_BREAK_DEAD     = 8'd17;

    // Control register one bit positions.
    localparam int CR1_ENABLE  = 0;
    localparam int CR1_UDIS    = 1;
    localparam int CR1_URS     = 2;
    localparam int CR1_OPM     = 3;
    localparam int CR1_DOWN    = 4;
    localparam int CR1_BUFFER  = 7;

    // Masks applied to written values.
    localparam logic [9:0]  CR1_WRITE_MASK = 10'h3ff;
    localparam logic [15:0] EGR_FLAG_MASK  = 16'h00de;
    localparam logic [15:0] UPDATE_FLAG    = 16'h0001;

    // Control bits that steer one counting step.
    typedef struct packed {
        logic enable;
        logic udis;
        logic opm;
        logic down;
    } gpt_tick_ctrl_t;

    // Events raised by one counting step.
    typedef struct packed {
        logic update_flag;
        logic clear_enable;
    } gpt_tick_evt_t;

endpackage

// ===== src/gpt_tick.sv =====
// One timer-clock tick: prescaler, up/down counter, repetition and update event.
`timescale 1ns / 1ps

module gpt_tick
    import gpt_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  gpt_tick_ctrl_t        ctrl,
    input  logic [15:0]           phase,
    input  logic [15:0]           psc_live,
    input  logic [15:0]           psc_written,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] reload_live,
    input  logic [COUNT_BITS-1:0] reload_written,
    input  logic [7:0]            rep_left,
    input  logic [7:0]            rep_written,
    output logic [15:0]           phase_next,
    output logic [15:0]           psc_live_next,
    output logic [COUNT_BITS-1:0] count_next,
    output logic [COUNT_BITS-1:0] reload_live_next,
    output logic [7:0]            rep_left_next,
    output gpt_tick_evt_t         evt
);

    logic overflow;

    // The counter passes its end at zero going down and at the reload value going up.
    assign overflow = ctrl.down ? (count == '0) : (count == reload_live);

    always_comb
    begin
        phase_next       = phase;
        psc_live_next    = psc_live;
        count_next       = count;
        reload_live_next = reload_live;
        rep_left_next    = rep_left;
        evt              = '0;
        if (ctrl.enable)
        begin
            if (phase < psc_live)
            begin
                phase_next = phase + 16'd1;
            end
            else
            begin
                phase_next = '0;
                if (!overflow)
                begin
                    // Counting up past a lowered reload value wraps around naturally.
                    count_next = ctrl.down ? (count - COUNT_BITS'(1))
                                           : (count + COUNT_BITS'(1));
                end
                else
                begin
                    // The repetition counter absorbs overflows before an update fires.
                    if (rep_left != 8'd0)
                    begin
                        rep_left_next = rep_left - 8'd1;
                    end
                    else
                    begin
                        if (!ctrl.udis)
                        begin
                            psc_live_next    = psc_written;
                            reload_live_next = reload_written;
                            rep_left_next    = rep_written;
                            evt.update_flag  = 1'b1;
                        end
                        evt.clear_enable = ctrl.opm;
                    end
                    count_next = ctrl.down ? reload_live_next : '0;
                end
            end
        end
    end

endmodule

// ===== src/general_purpose_timer_core.sv =====
// Top level of the general-purpose timer: register file, stream ports and result register.
`timescale 1ns / 1ps

// A COUNT_BITS-wide up/down timer with prescaler, auto-reload, repetition counter and
// event generation, driven by a stream of transactions: a timer tick, a register read or
// a masked register write (write_data AND write_mask). Every transaction produces exactly
// one result carrying the read data (zero unless a read) and both interrupt levels as they
// stand after the transaction. Each transaction is handled in the cycle it is accepted and
// its result appears in the output register on the next cycle; one transaction is accepted
// every cycle, limited only by the output register, which takes a new result whenever it is
// empty or being drained in the same cycle. Capture/compare registers are storage only.

module general_purpose_timer_core
    import gpt_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // reg_index[7:0], write_data[23:8], write_mask[39:24]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // read_data[15:0], upd_irq[16], compare_irq[17], zeros
);

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [15:0] CC_FLAG_MASK = 16'(((1 << CHANNELS) - 1) << 1);

    // Architectural registers.
    logic [9:0]            control_one_reg, control_one_next;
    logic [15:0]           control_two_reg, control_two_next;
    logic [15:0]           slave_mode_reg, slave_mode_next;
    logic [15:0]           irq_enable_reg, irq_enable_next;
    logic [15:0]           status_reg, status_next;
    logic [15:0]           mode_reg [2];
    logic [15:0]           mode_next [2];
    logic [15:0]           channel_enable_reg, channel_enable_next;
    logic [15:0]           psc_written_reg, psc_written_next;
    logic [15:0]           psc_live_reg, psc_live_next;
    logic [15:0]           phase_reg, phase_next;
    logic [COUNT_BITS-1:0] reload_written_reg, reload_written_next;
    logic [COUNT_BITS-1:0] reload_live_reg, reload_live_next;
    logic [7:0]            rep_written_reg, rep_written_next;
    logic [7:0]            rep_left_reg, rep_left_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [15:0]           compare_reg [CHANNELS];
    logic [15:0]           compare_next [CHANNELS];
    logic [15:0]           break_dead_reg, break_dead_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [23:0]           out_data_reg, out_data_next;

    // Transaction fields.
    logic                  accept;
    func_t                 func;
    logic [7:0]            reg_index;
    logic [15:0]           wval;
    logic [7:0]            ch_off;
    logic [CH_IW-1:0]      ch_sel;
    logic                  ch_ok;
    logic [COUNT_BITS-1:0] wval_count;
    logic [15:0]           read_data;
    logic                  upd_irq;
    logic                  compare_irq;

    // Tick unit signals.
    gpt_tick_ctrl_t        tick_ctrl;
    gpt_tick_evt_t         tick_evt;
    logic [15:0]           tick_phase;
    logic [15:0]           tick_psc_live;
    logic [COUNT_BITS-1:0] tick_count;
    logic [COUNT_BITS-1:0] tick_reload_live;
    logic [7:0]            tick_rep_left;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign func       = func_t'(s_tuser);
    assign reg_index  = s_tdata[7:0];
    assign wval       = s_tdata[23:8] & s_tdata[39:24];
    assign wval_count = COUNT_BITS'(wval);
    assign ch_off     = reg_index - IDX_COMPARE_0;
    assign ch_sel     = ch_off[CH_IW-1:0];
    assign ch_ok      = ch_off < 8'(CHANNELS);

    assign tick_ctrl.enable = control_one_reg[CR1_ENABLE];
    assign tick_ctrl.udis   = control_one_reg[CR1_UDIS];
    assign tick_ctrl.opm    = control_one_reg[CR1_OPM];
    assign tick_ctrl.down   = control_one_reg[CR1_DOWN];

    gpt_tick #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick (
        .ctrl             (tick_ctrl),
        .phase            (phase_reg),
        .psc_live         (psc_live_reg),
        .psc_written      (psc_written_reg),
        .count            (count_reg),
        .reload_live      (reload_live_reg),
        .reload_written   (reload_written_reg),
        .rep_left         (rep_left_reg),
        .rep_written      (rep_written_reg),
        .phase_next       (tick_phase),
        .psc_live_next    (tick_psc_live),
        .count_next       (tick_count),
        .reload_live_next (tick_reload_live),
        .rep_left_next    (tick_rep_left),
        .evt              (tick_evt)
    );

    // Register read multiplexer; reads have no side effects.
    always_comb
    begin
        read_data = '0;
        unique case (reg_index)
            IDX_CONTROL_ONE:    read_data = 16'(control_one_reg);
            IDX_CONTROL_TWO:    read_data = control_two_reg;
            IDX_SLAVE_MODE:     read_data = slave_mode_reg;
            IDX_IRQ_ENABLE:     read_data = irq_enable_reg;
            IDX_STATUS:         read_data = status_reg;
            IDX_MODE_0:         read_data = mode_reg[0];
            IDX_MODE_1:         read_data = mode_reg[1];
            IDX_CHANNEL_ENABLE: read_data = channel_enable_reg;
            IDX_COUNT:          read_data = 16'(count_reg);
            IDX_PRESCALE:       read_data = psc_written_reg;
            IDX_RELOAD:         read_data = 16'(reload_written_reg);
            IDX_REPEAT:         read_data = 16'(rep_written_reg);
            IDX_COMPARE_0, IDX_COMPARE_1, IDX_COMPARE_2, IDX_COMPARE_3:
            begin
                if (ch_ok)
                begin
                    read_data = compare_reg[ch_sel];
                end
            end
            IDX_BREAK_DEAD:     read_data = break_dead_reg;
            default:            read_data = '0;
        endcase
    end

    // Next state of the register file for the accepted transaction.
    always_comb
    begin
        control_one_next    = control_one_reg;
        control_two_next    = control_two_reg;
        slave_mode_next     = slave_mode_reg;
        irq_enable_next     = irq_enable_reg;
        status_next         = status_reg;
        mode_next           = mode_reg;
        channel_enable_next = channel_enable_reg;
        psc_written_next    = psc_written_reg;
        psc_live_next       = psc_live_reg;
        phase_next          = phase_reg;
        reload_written_next = reload_written_reg;
        reload_live_next    = reload_live_reg;
        rep_written_next    = rep_written_reg;
        rep_left_next       = rep_left_reg;
        count_next          = count_reg;
        compare_next        = compare_reg;
        break_dead_next     = break_dead_reg;
        if (accept)
        begin
            unique case (func)
                FUNC_TICK:
                begin
                    phase_next    = tick_phase;
                    psc_live_next = tick_psc_live;
                    count_next    = tick_count;
                    reload_live_next = tick_reload_live;
                    rep_left_next = tick_rep_left;
                    if (tick_evt.update_flag)
                    begin
                        status_next = status_reg | UPDATE_FLAG;
                    end
                    if (tick_evt.clear_enable)
                    begin
                        control_one_next[CR1_ENABLE] = 1'b0;
                    end
                end
                FUNC_READ:
                begin
                    // Reads leave all state untouched.
                end
                FUNC_WRITE:
                begin
                    unique case (reg_index)
                        IDX_CONTROL_ONE:
                        begin
                            control_one_next = wval[9:0] & CR1_WRITE_MASK;
                            if (!wval[CR1_BUFFER])
                            begin
                                reload_live_next = reload_written_reg;
                            end
                        end
                        IDX_CONTROL_TWO:    control_two_next = wval;
                        IDX_SLAVE_MODE:     slave_mode_next = wval;
                        IDX_IRQ_ENABLE:     irq_enable_next = wval;
                        IDX_STATUS:         status_next = status_reg & wval;
                        IDX_EVENT_GEN:
                        begin
                            // Forced update reloads everything and restarts the prescaler.
                            if (wval[0])
                            begin
                                psc_live_next    = psc_written_reg;
                                reload_live_next = reload_written_reg;
                                rep_left_next    = rep_written_reg;
                                if (!control_one_reg[CR1_URS])
                                begin
                                    status_next = status_reg | UPDATE_FLAG;
                                end
                                count_next = control_one_reg[CR1_DOWN] ? reload_written_reg
                                                                       : '0;
                                phase_next = '0;
                            end
                            status_next = status_next | (wval & EGR_FLAG_MASK);
                        end
                        IDX_MODE_0:         mode_next[0] = wval;
                        IDX_MODE_1:         mode_next[1] = wval;
                        IDX_CHANNEL_ENABLE: channel_enable_next = wval;
                        IDX_COUNT:          count_next = wval_count;
                        IDX_PRESCALE:       psc_written_next = wval;
                        IDX_RELOAD:
                        begin
                            // Unbuffered reload takes effect at once and clamps the count.
                            reload_written_next = wval_count;
                            if (!control_one_reg[CR1_BUFFER])
                            begin
                                reload_live_next = wval_count;
                                if (count_reg > wval_count)
                                begin
                                    count_next = wval_count;
                                end
                            end
                        end
                        IDX_REPEAT:         rep_written_next = wval[7:0];
                        IDX_COMPARE_0, IDX_COMPARE_1, IDX_COMPARE_2, IDX_COMPARE_3:
                        begin
                            if (ch_ok)
                            begin
                                compare_next[ch_sel] = wval;
                            end
                        end
                        IDX_BREAK_DEAD:     break_dead_next = wval;
                        default:
                        begin
                            // Unlisted registers ignore writes.
                        end
                    endcase
                end
                default:
                begin
                    // Undefined item kind does nothing.
                end
            endcase
        end
    end

    // Result of the transaction and output register handshake.
    assign upd_irq     = |(status_next & irq_enable_next & UPDATE_FLAG);
    assign compare_irq = |(status_next & irq_enable_next & CC_FLAG_MASK);

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {6'd0, compare_irq, upd_irq,
                              (func == FUNC_READ) ? read_data : 16'd0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            control_one_reg    <= '0;
            control_two_reg    <= '0;
            slave_mode_reg     <= '0;
            irq_enable_reg     <= '0;
            status_reg         <= '0;
            mode_reg[0]        <= '0;
            mode_reg[1]        <= '0;
            channel_enable_reg <= '0;
            psc_written_reg    <= '0;
            psc_live_reg       <= '0;
            phase_reg          <= '0;
            reload_written_reg <= '1;
            reload_live_reg    <= '1;
            rep_written_reg    <= '0;
            rep_left_reg       <= '0;
            count_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                compare_reg[i] <= '0;
            end
            break_dead_reg     <= '0;
        end
        else
        begin
            out_valid_reg      <= out_valid_next;
            control_one_reg    <= control_one_next;
            control_two_reg    <= control_two_next;
            slave_mode_reg     <= slave_mode_next;
            irq_enable_reg     <= irq_enable_next;
            status_reg         <= status_next;
            mode_reg           <= mode_next;
            channel_enable_reg <= channel_enable_next;
            psc_written_reg    <= psc_written_next;
            psc_live_reg       <= psc_live_next;
            phase_reg          <= phase_next;
            reload_written_reg <= reload_written_next;
            reload_live_reg    <= reload_live_next;
            rep_written_reg    <= rep_written_next;
            rep_left_reg       <= rep_left_next;
            count_reg          <= count_next;
            compare_reg        <= compare_next;
            break_dead_reg     <= break_dead_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Every accepted transaction leaves a result in the output register.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // A waiting result carries the update level of the current state.
    a_upd_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16] == (status_reg[0] & irq_enable_reg[0])))
        else $error("upd_irq does not match status and enable");

    // The prescaler phase never runs past the live prescale value.
    a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= psc_live_reg)
        else $error("prescaler phase exceeds live prescale value");

endmodule
